@@ rtl/core/sfp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared constants and types of the sample frame parser: frame codes,
// payload layout and the constants of the code-to-voltage scaling.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // number of converters whose blocks share one data frame (1 to 8)
  localparam int CONVERTERS   = 1;
  localparam int BLOCK_BYTES  = 27;
  localparam int STATUS_BYTES = 3;
  localparam int PAYLOAD_MAX  = BLOCK_BYTES * CONVERTERS;
  localparam int ADDR_W       = $clog2(PAYLOAD_MAX);
  localparam int NUM_SAMPLES  = 8 * CONVERTERS;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] CMD_DATA  = 8'h01;
  localparam logic [7:0] CMD_REPLY = 8'h03;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPLY  = 1'b1;

  localparam int CH_W    = 6;
  localparam int CODE_W  = 24;
  localparam int VOLT_W  = 23;
  localparam int REPLY_W = 8;
  localparam int TDATA_W = 64;

  // voltage = round(mag * 11*2^18 / 6990505), ties away from zero,
  // i.e. floor((mag * VOLT_MUL + VOLT_BIAS) / VOLT_DIV)
  localparam int DIV_NUM_W = 46;
  localparam int QUOT_W    = 22;
  localparam int REM_W     = DIV_NUM_W - QUOT_W;
  localparam logic [22:0] VOLT_MUL  = 23'd5767168;
  localparam logic [22:0] VOLT_BIAS = 23'd6990505;
  localparam logic [REM_W-1:0] VOLT_DIV = 24'd13981010;

  // VOLT_RECIP = 11 * floor(2^47 / 6990505); (mag * VOLT_RECIP) >> RECIP_SHIFT
  // is the quotient or one below it
  localparam int PROD_W      = 51;
  localparam int RECIP_SHIFT = 29;
  localparam logic [27:0] VOLT_RECIP = 28'd221459304;

  typedef struct packed {
    logic start;
    logic reply;
  } emit_req_t;

endpackage

@@ rtl/core/sfp_payload_mem.sv @@
// ----------------------------------------------------------------------------
// sfp_payload_mem
// Payload byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sfp_payload_mem
  import sfp_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [PAYLOAD_MAX];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/sfp_volt_div.sv @@
// ----------------------------------------------------------------------------
// sfp_volt_div
// Division by the fixed voltage divisor: reciprocal multiplication, then one
// compare-and-correct step, registered in prod, est, rem and quot.
// ----------------------------------------------------------------------------
module sfp_volt_div
  import sfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CODE_W-1:0] mag,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  logic [PROD_W-1:0]    prod;
  logic [DIV_NUM_W-1:0] numer;
  logic [QUOT_W-1:0]    est;
  logic [DIV_NUM_W-1:0] rem;
  logic [2:0]           stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], start};
      done  <= stage[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= PROD_W'(mag) * PROD_W'(VOLT_RECIP);
      numer <= DIV_NUM_W'(mag) * DIV_NUM_W'(VOLT_MUL) + DIV_NUM_W'(VOLT_BIAS);
    end
    // estimate is low by at most one
    est  <= prod[RECIP_SHIFT +: QUOT_W];
    rem  <= numer - DIV_NUM_W'(est) * DIV_NUM_W'(VOLT_DIV);
    quot <= (rem >= DIV_NUM_W'(VOLT_DIV)) ? QUOT_W'(est + 1'b1) : est;
  end

endmodule

@@ rtl/core/sfp_emitter.sv @@
// ----------------------------------------------------------------------------
// sfp_emitter
// Walks a verified payload in the store, assembles big-endian codes, scales
// them to volts and presents the results in an output register, or for a
// reply frame presents the stored reply byte there.
module sfp_emitter
  import sfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  emit_req_t          req,
  output logic               busy,
  output logic               rd_en,
  output logic [ADDR_W-1:0]  rd_addr,
  input  logic [7:0]         rd_data,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_READ,
    E_CONV,
    E_DIV,
    E_SEND,
    E_RPL_RD,
    E_RPL_CAP
  } emit_state_t;

  emit_state_t              state;
  logic [ADDR_W-1:0]        addr;
  logic [1:0]               rd_idx;
  logic [CH_W-1:0]          samp;
  logic [CODE_W-1:0]        code;
  logic [CODE_W-1:0]        mag;
  logic                     div_start;
  logic                     div_done;
  logic [QUOT_W-1:0]        quot;

  logic                     out_kind;
  logic [CH_W-1:0]          out_channel;
  logic [CODE_W-1:0]        out_code;
  logic [VOLT_W-1:0]        out_volt;
  logic [REPLY_W-1:0]       out_reply;
  logic                     out_last;

  always_comb begin
    mag       = code[CODE_W-1] ? CODE_W'(-code) : code;
    div_start = (state == E_CONV);
    rd_en     = (state == E_RPL_RD) || ((state == E_READ) && (rd_idx != 2'd3));
    rd_addr   = (state == E_RPL_RD) ? '0 : addr;
    busy      = (state != E_IDLE);
  end

  sfp_volt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (mag),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      rd_idx <= '0;
      samp   <= '0;
    end else begin
      case (state)
        E_IDLE: begin
          if (req.start) begin
            if (req.reply) begin
              state <= E_RPL_RD;
            end else begin
              addr   <= ADDR_W'(STATUS_BYTES);
              samp   <= '0;
              rd_idx <= '0;
              state  <= E_READ;
            end
          end
        end
        E_READ: begin
          // read data arrives in the cycle after its address is issued
          if (rd_idx != 2'd0) begin
            code <= {code[CODE_W-9:0], rd_data};
          end
          if (rd_idx != 2'd3) begin
            addr   <= ADDR_W'(addr + 1'b1);
            rd_idx <= 2'(rd_idx + 2'd1);
          end else begin
            if (samp[2:0] == 3'd7) begin
              addr <= ADDR_W'(addr + ADDR_W'(STATUS_BYTES));
            end
            state <= E_CONV;
          end
        end
        E_CONV: begin
          state <= E_DIV;
        end
        E_DIV: begin
          if (div_done) begin
            out_kind    <= KIND_SAMPLE;
            out_channel <= samp;
            out_code    <= code;
            out_volt    <= code[CODE_W-1] ? VOLT_W'(-{1'b0, quot}) : VOLT_W'({1'b0, quot});
            out_reply   <= '0;
            out_last    <= (samp == CH_W'(NUM_SAMPLES - 1));
            state       <= E_SEND;
          end
        end
        E_RPL_RD: begin
          state <= E_RPL_CAP;
        end
        E_RPL_CAP: begin
          out_kind    <= KIND_REPLY;
          out_channel <= '0;
          out_code    <= '0;
          out_volt    <= '0;
          out_reply   <= rd_data;
          out_last    <= 1'b1;
          state       <= E_SEND;
        end
        E_SEND: begin
          if (m_tready) begin
            if (out_last) begin
              state <= E_IDLE;
            end else begin
              samp   <= CH_W'(samp + 1'b1);
              rd_idx <= '0;
              state  <= E_READ;
            end
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = (state == E_SEND);
  assign m_tdata  = {3'b000, out_reply, out_volt, out_code, out_channel};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

@@ rtl/core/sample_frame_parser.sv @@
// ----------------------------------------------------------------------------
// sample_frame_parser
// Hunts for the sync header, stores and sums the payload, checks the
// trailing checksum and releases samples or the reply byte of good frames.
// ----------------------------------------------------------------------------
// Header, payload and checksum bytes are taken one per cycle while no frame
// is being emitted. After a good checksum the input stalls while results go
// out: a reply is read from the store, captured and sent; each sample is read
// from the store byte by byte, its scaling is started, it is scaled by
// reciprocal multiplication and it is sent once the output accepts it.
// Synchronous reset returns to hunting the first sync byte; the payload store
// is not cleared and is always rewritten before it is read.
module sample_frame_parser
  import sfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] rx_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  // [5:0] channel, [29:6] sample_code, [52:30] voltage_fixed,
  // [60:53] reply_value, [63:61] zero
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser,   // [0] result_kind
  output logic               m_tlast
);

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CMD,
    PH_DATA,
    PH_CHECK
  } phase_t;

  phase_t      phase;
  logic [7:0]  frame_command;
  logic [7:0]  running_sum;
  logic [7:0]  byte_count;
  logic [7:0]  expected_length;
  logic [7:0]  count_next;
  logic        accept;
  logic        wr_en;
  logic        emit_busy;
  emit_req_t   req;
  logic        rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]  rd_data;

  always_comb begin
    accept     = s_tvalid && s_tready;
    count_next = 8'(byte_count + 8'd1);
    wr_en      = accept && (phase == PH_DATA) && (byte_count < 8'(PAYLOAD_MAX));
    req.start  = accept && (phase == PH_CHECK) && (running_sum == s_tdata) &&
                 ((frame_command == CMD_DATA) || (frame_command == CMD_REPLY));
    req.reply  = (frame_command == CMD_REPLY);
  end

  // the store is written only while no frame is being emitted
  assign s_tready = !emit_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC1;
      frame_command   <= '0;
      running_sum     <= '0;
      byte_count      <= '0;
      expected_length <= '0;
    end else if (accept) begin
      case (phase)
        PH_SYNC2: begin
          phase <= (s_tdata == SYNC_BYTE) ? PH_CMD : PH_SYNC1;
        end
        PH_CMD: begin
          frame_command <= s_tdata;
          running_sum   <= '0;
          byte_count    <= '0;
          if (s_tdata == CMD_DATA) begin
            expected_length <= 8'(PAYLOAD_MAX);
            phase           <= PH_DATA;
          end else if (s_tdata == CMD_REPLY) begin
            expected_length <= 8'd1;
            phase           <= PH_DATA;
          end else begin
            phase <= PH_SYNC1;
          end
        end
        PH_DATA: begin
          running_sum <= 8'(running_sum + s_tdata);
          byte_count  <= count_next;
          if (count_next >= expected_length) begin
            phase <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase <= PH_SYNC1;
        end
        default: begin
          phase <= (s_tdata == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

  sfp_payload_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (byte_count[ADDR_W-1:0]),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sfp_emitter u_emit (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .busy     (emit_busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
